// File: hw/rtl/clock_setting_key_controller_macros.svh
// Assertion macros for the clock setting key controller.
// Each macro checks an implication on the rising clock edge, disabled in reset.
`ifndef CLOCK_SETTING_KEY_CONTROLLER_MACROS_SVH
`define CLOCK_SETTING_KEY_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define CSKC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cskc same-cycle check failed");

// Next-cycle implication.
`define CSKC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cskc next-cycle check failed");

`else

`define CSKC_ASSERT_NOW(label, clk, rst, ante, cons)
`define CSKC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/cskc_pkg.sv
package cskc_pkg;

   // Debouncer key codes.
   typedef enum logic [1:0] {
      KEY_NONE   = 2'd0,
      KEY_UP     = 2'd1,
      KEY_DOWN   = 2'd2,
      KEY_TOGGLE = 2'd3
   } key_code_type;

   // Mode key timing phases; the unused code behaves as idle.
   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_QUALIFY = 2'd1,
      PHASE_HELD    = 2'd2
   } mode_phase_type;

   typedef enum logic [1:0] {
      PRESS_NONE  = 2'd0,
      PRESS_SHORT = 2'd1,
      PRESS_LONG  = 2'd2
   } press_event_type;

   typedef enum logic [1:0] {
      WRITE_NONE  = 2'd0,
      WRITE_TIME  = 2'd1,
      WRITE_DATE  = 2'd2,
      WRITE_ALARM = 2'd3
   } write_kind_type;

   // Configuration register indexes.
   localparam logic CSR_LONG_PRESS    = 1'b0;
   localparam logic CSR_QUALIFY_TICKS = 1'b1;

   localparam logic [15:0] LONG_PRESS_RESET    = 16'd1000;
   localparam logic [7:0]  QUALIFY_TICKS_RESET = 8'd10;

   // Selectable fields.
   localparam logic [3:0] FIELD_HOUR         = 4'd1;
   localparam logic [3:0] FIELD_MINUTE       = 4'd2;
   localparam logic [3:0] FIELD_SECOND       = 4'd3;
   localparam logic [3:0] FIELD_YEAR         = 4'd4;
   localparam logic [3:0] FIELD_MONTH        = 4'd5;
   localparam logic [3:0] FIELD_DAY          = 4'd6;
   localparam logic [3:0] FIELD_WEEKDAY      = 4'd7;
   localparam logic [3:0] FIELD_ALARM_HOUR   = 4'd8;
   localparam logic [3:0] FIELD_ALARM_MINUTE = 4'd9;
   localparam logic [3:0] FIELD_ALARM_SECOND = 4'd10;
   localparam logic [3:0] FIELD_ALARM_WDAY   = 4'd11;

   // The debouncer decides on every third sample.
   localparam logic [7:0] SAMPLE_DECIDE = 8'd3;

   typedef struct packed {
      logic       up_key_level;
      logic       mode_key_level;
      logic       down_key_level;
      logic       toggle_key_level;
      logic [4:0] rtc_hour;
      logic [5:0] rtc_minute;
      logic [5:0] rtc_second;
      logic [6:0] rtc_year;
      logic [3:0] rtc_month;
      logic [4:0] rtc_day;
      logic [2:0] rtc_weekday;
   } cskc_req_type;

   typedef struct packed {
      logic            first_led;
      logic            second_led;
      logic            beeper;
      logic            edit_on;
      logic [3:0]      field_index;
      press_event_type press_event;
      write_kind_type  write_kind;
      logic [6:0]      slot_a;
      logic [5:0]      slot_b;
      logic [5:0]      slot_c;
      logic [5:0]      slot_d;
   } cskc_rsp_type;

   // Step a field with wrap: v >= hi steps up to lo, v <= lo down to hi.
   function automatic logic [6:0] step_value(input logic [6:0] v, input logic [6:0] lo,
                                             input logic [6:0] hi, input logic up);
      logic [6:0] r;
      if (up) begin
         r = (v >= hi) ? lo : v + 7'd1;
      end else begin
         r = (v <= lo) ? hi : v - 7'd1;
      end
      return r;
   endfunction

   // Days in a month; a month outside the year counts as 31 days.
   function automatic logic [6:0] month_days(input logic [3:0] month, input logic [6:0] year);
      logic [6:0] d;
      if (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11) begin
         d = 7'd30;
      end else if (month == 4'd2) begin
         d = (year[1:0] == 2'd0) ? 7'd29 : 7'd28;
      end else begin
         d = 7'd31;
      end
      return d;
   endfunction

endpackage

// File: hw/rtl/clock_setting_key_controller.sv
// Clock setting key controller.
// Each beat on the req channel is one 1 ms tick: four key levels and a
// snapshot of the real-time clock. Each accepted beat yields exactly one
// beat on the rsp channel: LED and beeper states, edit mode, the selected
// field, the mode key event of that tick and an optional time, date or
// alarm write with up to four values.
// The csr port sets the long press threshold (index 0) and the mode key
// qualify time (index 1); write only while the block is idle.
// rsp_valid rises in the cycle after a req beat is accepted. One beat is
// accepted every cycle: all per-tick logic sits between the request port
// and the single result register, and req_ready is high whenever the
// result register is empty or is being taken in the same cycle.
// When the receiver stalls, the result holds and req_ready drops until
// it is taken. Synchronous reset empties the result register, restores
// the register defaults, arms the debouncer, leaves edit mode, selects
// the hour field and clears the LEDs, beeper and alarm time.
`include "clock_setting_key_controller_macros.svh"

module clock_setting_key_controller
   import cskc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  cskc_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output cskc_rsp_type rsp_data,
   input  logic         csr_write_en,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);

   // Configuration registers.
   logic [15:0] long_press_ff;
   logic [7:0]  qualify_ff;

   // Debouncer state.
   logic         armed_ff, armed_in;
   logic [7:0]   sample_ff, sample_in;
   key_code_type cand_new_ff, cand_new_in;
   key_code_type cand_mid_ff, cand_mid_in;
   key_code_type cand_old_ff, cand_old_in;

   // Mode key state.
   mode_phase_type phase_ff, phase_in;
   logic [15:0]    hold_ff, hold_in;
   logic           edit_ff, edit_in;
   logic [3:0]     field_ff, field_in;

   // Alarm and indicator state.
   logic [4:0] alarm_hour_ff, alarm_hour_in;
   logic [5:0] alarm_minute_ff, alarm_minute_in;
   logic [5:0] alarm_second_ff, alarm_second_in;
   logic [2:0] alarm_wday_ff, alarm_wday_in;
   logic       led1_ff, led1_in;
   logic       led2_ff, led2_in;
   logic       beep_ff, beep_in;

   // Result register.
   logic         rsp_valid_ff, rsp_valid_in;
   cskc_rsp_type rsp_ff, rsp_in;

   logic            req_fire;
   logic            busy;
   press_event_type press_event;
   logic [15:0]     hold_inc;
   key_code_type    key;
   key_code_type    key_sample;
   logic            any_key;
   logic            key_step;
   write_kind_type  kind;
   logic [6:0]      slot_a, slot_b, slot_c, slot_d;
   logic [6:0]      hour_v, minute_v, second_v, year_v, month_v, day_v, wday_v;
   logic [6:0]      ahour_v, aminute_v, asecond_v, awday_v;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= LONG_PRESS_RESET;
         qualify_ff    <= QUALIFY_TICKS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LONG_PRESS:    long_press_ff <= csr_wdata;
            CSR_QUALIFY_TICKS: qualify_ff    <= csr_wdata[7:0];
            default:           long_press_ff <= long_press_ff;
         endcase
      end
   end

   // Mode key phase machine: qualify, then time the hold until release.
   always_comb begin
      phase_in    = phase_ff;
      hold_in     = hold_ff;
      edit_in     = edit_ff;
      field_in    = field_ff;
      busy        = 1'b0;
      press_event = PRESS_NONE;
      hold_inc    = (hold_ff == 16'hFFFF) ? hold_ff : hold_ff + 16'd1;
      unique case (phase_ff)
         PHASE_QUALIFY: begin
            hold_in = hold_inc;
            if (hold_inc >= {8'd0, qualify_ff}) begin
               hold_in = '0;
               if (!req_data.mode_key_level) begin
                  phase_in = PHASE_HELD;
                  busy     = 1'b1;
               end else begin
                  phase_in = PHASE_IDLE;
               end
            end else begin
               busy = 1'b1;
            end
         end
         PHASE_HELD: begin
            if (!req_data.mode_key_level) begin
               hold_in = hold_inc;
               busy    = 1'b1;
            end else begin
               if (hold_ff > long_press_ff) begin
                  edit_in     = !edit_ff;
                  press_event = PRESS_LONG;
               end else begin
                  press_event = PRESS_SHORT;
                  if (edit_ff) begin
                     field_in = (field_ff >= FIELD_ALARM_WDAY) ? FIELD_HOUR
                                                               : field_ff + 4'd1;
                  end
               end
               hold_in  = '0;
               phase_in = PHASE_IDLE;
            end
         end
         default: begin
            phase_in = PHASE_IDLE;
            if (!req_data.mode_key_level) begin
               phase_in = PHASE_QUALIFY;
               hold_in  = '0;
               busy     = 1'b1;
            end
         end
      endcase
   end

   // Three-sample debouncer, frozen while the mode key is busy.
   always_comb begin
      any_key = req_data.up_key_level || !req_data.down_key_level ||
                !req_data.toggle_key_level;
      if (req_data.up_key_level) begin
         key_sample = KEY_UP;
      end else if (!req_data.down_key_level) begin
         key_sample = KEY_DOWN;
      end else begin
         key_sample = KEY_TOGGLE;
      end
      armed_in    = armed_ff;
      sample_in   = sample_ff;
      cand_new_in = cand_new_ff;
      cand_mid_in = cand_mid_ff;
      cand_old_in = cand_old_ff;
      key         = KEY_NONE;
      if (!busy) begin
         cand_old_in = cand_mid_ff;
         cand_mid_in = cand_new_ff;
         sample_in   = sample_ff + 8'd1;
         if (armed_ff && any_key) begin
            cand_new_in = key_sample;
            if (sample_in == SAMPLE_DECIDE) begin
               sample_in = '0;
               if (cand_mid_ff == key_sample && cand_new_ff == key_sample) begin
                  key      = key_sample;
                  armed_in = 1'b0;
               end
            end
         end else if (!any_key) begin
            armed_in  = 1'b1;
            sample_in = '0;
         end
      end
   end

   // Field stepping in edit mode, indicator toggles otherwise.
   always_comb begin
      hour_v    = {2'd0, req_data.rtc_hour};
      minute_v  = {1'b0, req_data.rtc_minute};
      second_v  = {1'b0, req_data.rtc_second};
      year_v    = req_data.rtc_year;
      month_v   = {3'd0, req_data.rtc_month};
      day_v     = {2'd0, req_data.rtc_day};
      wday_v    = {4'd0, req_data.rtc_weekday};
      ahour_v   = {2'd0, alarm_hour_ff};
      aminute_v = {1'b0, alarm_minute_ff};
      asecond_v = {1'b0, alarm_second_ff};
      awday_v   = {4'd0, alarm_wday_ff};
      kind      = WRITE_NONE;
      led1_in   = led1_ff;
      led2_in   = led2_ff;
      beep_in   = beep_ff;
      key_step  = (key == KEY_UP);
      slot_a    = '0;
      slot_b    = '0;
      slot_c    = '0;
      slot_d    = '0;
      if (edit_in) begin
         if (key == KEY_UP || key == KEY_DOWN) begin
            unique case (field_in)
               FIELD_HOUR: begin
                  hour_v = step_value(hour_v, 7'd0, 7'd23, key_step);
                  kind   = WRITE_TIME;
               end
               FIELD_MINUTE: begin
                  minute_v = step_value(minute_v, 7'd0, 7'd59, key_step);
                  kind     = WRITE_TIME;
               end
               FIELD_SECOND: begin
                  second_v = step_value(second_v, 7'd0, 7'd59, key_step);
                  kind     = WRITE_TIME;
               end
               FIELD_YEAR: begin
                  year_v = step_value(year_v, 7'd0, 7'd99, key_step);
                  kind   = WRITE_DATE;
               end
               FIELD_MONTH: begin
                  month_v = step_value(month_v, 7'd1, 7'd12, key_step);
                  kind    = WRITE_DATE;
               end
               FIELD_DAY: begin
                  day_v = step_value(day_v, 7'd1,
                                     month_days(req_data.rtc_month, req_data.rtc_year),
                                     key_step);
                  kind  = WRITE_DATE;
               end
               FIELD_WEEKDAY: begin
                  wday_v = step_value(wday_v, 7'd1, 7'd7, key_step);
                  kind   = WRITE_DATE;
               end
               FIELD_ALARM_HOUR: begin
                  ahour_v = step_value(ahour_v, 7'd0, 7'd23, key_step);
                  kind    = WRITE_ALARM;
               end
               FIELD_ALARM_MINUTE: begin
                  aminute_v = step_value(aminute_v, 7'd0, 7'd59, key_step);
                  kind      = WRITE_ALARM;
               end
               FIELD_ALARM_SECOND: begin
                  asecond_v = step_value(asecond_v, 7'd0, 7'd59, key_step);
                  kind      = WRITE_ALARM;
               end
               FIELD_ALARM_WDAY: begin
                  awday_v = step_value(awday_v, 7'd1, 7'd7, key_step);
                  kind    = WRITE_ALARM;
               end
               default: kind = WRITE_NONE;
            endcase
         end
      end else begin
         priority if (key == KEY_UP) begin
            led1_in = !led1_ff;
         end else if (key == KEY_DOWN) begin
            led2_in = !led2_ff;
         end else if (key == KEY_TOGGLE) begin
            beep_in = !beep_ff;
         end else begin
            beep_in = beep_ff;
         end
      end
      unique case (kind)
         WRITE_TIME: begin
            slot_a = hour_v;
            slot_b = minute_v;
            slot_c = second_v;
         end
         WRITE_DATE: begin
            slot_a = year_v;
            slot_b = month_v;
            slot_c = day_v;
            slot_d = wday_v;
         end
         WRITE_ALARM: begin
            slot_a = awday_v;
            slot_b = ahour_v;
            slot_c = aminute_v;
            slot_d = asecond_v;
         end
         default: slot_a = '0;
      endcase
      alarm_hour_in   = ahour_v[4:0];
      alarm_minute_in = aminute_v[5:0];
      alarm_second_in = asecond_v[5:0];
      alarm_wday_in   = awday_v[2:0];
   end

   // Result beat assembly.
   always_comb begin
      rsp_in.first_led   = led1_in;
      rsp_in.second_led  = led2_in;
      rsp_in.beeper      = beep_in;
      rsp_in.edit_on     = edit_in;
      rsp_in.field_index = field_in;
      rsp_in.press_event = press_event;
      rsp_in.write_kind  = kind;
      rsp_in.slot_a      = slot_a;
      rsp_in.slot_b      = slot_b[5:0];
      rsp_in.slot_c      = slot_c[5:0];
      rsp_in.slot_d      = slot_d[5:0];
      rsp_valid_in       = req_fire || (rsp_valid_ff && !rsp_ready);
   end

   // Tick state advances only on an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff        <= 1'b1;
         sample_ff       <= '0;
         cand_new_ff     <= KEY_NONE;
         cand_mid_ff     <= KEY_NONE;
         cand_old_ff     <= KEY_NONE;
         phase_ff        <= PHASE_IDLE;
         hold_ff         <= '0;
         edit_ff         <= 1'b0;
         field_ff        <= FIELD_HOUR;
         alarm_hour_ff   <= '0;
         alarm_minute_ff <= '0;
         alarm_second_ff <= '0;
         alarm_wday_ff   <= 3'd1;
         led1_ff         <= 1'b0;
         led2_ff         <= 1'b0;
         beep_ff         <= 1'b0;
      end else if (req_fire) begin
         armed_ff        <= armed_in;
         sample_ff       <= sample_in;
         cand_new_ff     <= cand_new_in;
         cand_mid_ff     <= cand_mid_in;
         cand_old_ff     <= cand_old_in;
         phase_ff        <= phase_in;
         hold_ff         <= hold_in;
         edit_ff         <= edit_in;
         field_ff        <= field_in;
         alarm_hour_ff   <= alarm_hour_in;
         alarm_minute_ff <= alarm_minute_in;
         alarm_second_ff <= alarm_second_in;
         alarm_wday_ff   <= alarm_wday_in;
         led1_ff         <= led1_in;
         led2_ff         <= led2_in;
         beep_ff         <= beep_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // A write is only ever reported while editing.
   `CSKC_ASSERT_NOW(a_write_in_edit, clock, reset,
      rsp_valid_ff && (rsp_ff.write_kind != WRITE_NONE), rsp_ff.edit_on)
   // The selected field stays within the eleven fields.
   `CSKC_ASSERT_NOW(a_field_range, clock, reset, 1'b1,
      (field_ff >= FIELD_HOUR) && (field_ff <= FIELD_ALARM_WDAY))
   // Every accepted tick produces a result beat in the next cycle.
   `CSKC_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, req_fire, rsp_valid_ff)
   // A reported key locks the debouncer until all keys are released.
   `CSKC_ASSERT_NEXT(a_key_disarms, clock, reset,
      req_fire && (key != KEY_NONE), !armed_ff)
   // Debouncer candidates and counter hold while the mode key is busy.
   `CSKC_ASSERT_NEXT(a_busy_freezes, clock, reset, req_fire && busy,
      $stable(sample_ff) && $stable(cand_new_ff))

endmodule

// File: test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cskc_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int IDLE_PCT    = 20;
   localparam int SETTLE      = 4;

   logic         clock;
   logic         reset        = 1'b1;
   logic         req_valid    = 1'b0;
   logic         req_ready;
   cskc_req_type req_data     = '0;
   logic         rsp_valid;
   logic         rsp_ready    = 1'b0;
   cskc_rsp_type rsp_data;
   logic         csr_write_en = 1'b0;
   logic         csr_index    = CSR_LONG_PRESS;
   logic [15:0]  csr_wdata    = '0;

   clock_setting_key_controller DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Shadow copy of the controller: registers and per-tick state.
   logic [15:0]    long_cfg;
   logic [7:0]     qualify_cfg;
   logic           armed;
   logic [7:0]     sample_cnt;
   key_code_type   cand_new, cand_mid, cand_old;
   mode_phase_type phase;
   logic [15:0]    hold_cnt;
   logic           edit_mode;
   logic [3:0]     field_sel;
   logic [4:0]     alarm_hr;
   logic [5:0]     alarm_min, alarm_sec;
   logic [2:0]     alarm_wd;
   logic           led_one, led_two, beeper_on;

   // Panel states still owed by the block, oldest first.
   cskc_rsp_type panel_due[$];

   int           items_sent  = 0;
   int           fail_count  = 0;
   int           cycle_count = 0;
   int           writes_seen = 0;
   int           long_seen   = 0;
   int           short_seen  = 0;
   bit           steady_flow = 1'b0;
   bit           rtc_pinned  = 1'b0;
   cskc_req_type pinned_rtc  = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding",
                  cycle_count, panel_due.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver side: stall at random unless the flow is held steady.
   always @(negedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
   end

   task automatic clear_model();
      long_cfg    = LONG_PRESS_RESET;
      qualify_cfg = QUALIFY_TICKS_RESET;
      armed       = 1'b1;
      sample_cnt  = '0;
      cand_new    = KEY_NONE;
      cand_mid    = KEY_NONE;
      cand_old    = KEY_NONE;
      phase       = PHASE_IDLE;
      hold_cnt    = '0;
      edit_mode   = 1'b0;
      field_sel   = FIELD_HOUR;
      alarm_hr    = '0;
      alarm_min   = '0;
      alarm_sec   = '0;
      alarm_wd    = 3'd1;
      led_one     = 1'b0;
      led_two     = 1'b0;
      beeper_on   = 1'b0;
   endtask

   function automatic int step_wrap(input int v, input int lo, input int hi, input bit inc);
      if (inc) begin
         return (v >= hi) ? lo : v + 1;
      end
      return (v <= lo) ? hi : v - 1;
   endfunction

   // Month length; anything outside January..December counts as 31 days.
   function automatic int days_in(input int month, input int year);
      if (month == 4 || month == 6 || month == 9 || month == 11) begin
         return 30;
      end
      if (month == 2) begin
         return (year % 4 == 0) ? 29 : 28;
      end
      return 31;
   endfunction

   // Three-sample debouncer, locked after a report until all keys are up.
   function automatic key_code_type sample_keys(input cskc_req_type r);
      key_code_type found;
      logic         any;
      found = KEY_NONE;
      any = r.up_key_level || !r.down_key_level || !r.toggle_key_level;
      cand_old = cand_mid;
      cand_mid = cand_new;
      sample_cnt = sample_cnt + 8'd1;
      if (armed && any) begin
         if (r.up_key_level) begin
            cand_new = KEY_UP;
         end else if (!r.down_key_level) begin
            cand_new = KEY_DOWN;
         end else begin
            cand_new = KEY_TOGGLE;
         end
         if (sample_cnt == SAMPLE_DECIDE) begin
            sample_cnt = '0;
            if (cand_old == cand_new && cand_mid == cand_new) begin
               found = cand_new;
               armed = 1'b0;
            end
         end
      end else if (!any) begin
         armed = 1'b1;
         sample_cnt = '0;
      end
      return found;
   endfunction

   // One tick of the controller: returns the panel state the block must show.
   function automatic cskc_rsp_type advance_controller(input cskc_req_type r);
      cskc_rsp_type o;
      logic         pressed, busy, inc;
      key_code_type key;
      int           hr, mi, se, yr, mo, dy, wd;
      o = '0;
      pressed = !r.mode_key_level;
      busy = 1'b0;
      key = KEY_NONE;
      hr = r.rtc_hour;
      mi = r.rtc_minute;
      se = r.rtc_second;
      yr = r.rtc_year;
      mo = r.rtc_month;
      dy = r.rtc_day;
      wd = r.rtc_weekday;

      // Mode key: qualify, then time the hold until release.
      case (phase)
         PHASE_QUALIFY: begin
            if (hold_cnt != 16'hFFFF) hold_cnt = hold_cnt + 16'd1;
            if (hold_cnt >= qualify_cfg) begin
               hold_cnt = '0;
               if (pressed) begin
                  phase = PHASE_HELD;
                  busy = 1'b1;
               end else begin
                  phase = PHASE_IDLE;
               end
            end else begin
               busy = 1'b1;
            end
         end
         PHASE_HELD: begin
            if (pressed) begin
               if (hold_cnt != 16'hFFFF) hold_cnt = hold_cnt + 16'd1;
               busy = 1'b1;
            end else begin
               if (hold_cnt > long_cfg) begin
                  edit_mode = !edit_mode;
                  o.press_event = PRESS_LONG;
               end else begin
                  o.press_event = PRESS_SHORT;
                  if (edit_mode) begin
                     field_sel = field_sel + 4'd1;
                     if (field_sel > FIELD_ALARM_WDAY) field_sel = FIELD_HOUR;
                  end
               end
               hold_cnt = '0;
               phase = PHASE_IDLE;
            end
         end
         default: begin
            phase = PHASE_IDLE;
            if (pressed) begin
               phase = PHASE_QUALIFY;
               hold_cnt = '0;
               busy = 1'b1;
            end
         end
      endcase

      if (!busy) key = sample_keys(r);

      // Edit mode steps the selected field; otherwise keys flip the outputs.
      if (edit_mode) begin
         if (key == KEY_UP || key == KEY_DOWN) begin
            inc = (key == KEY_UP);
            case (field_sel)
               FIELD_HOUR: begin
                  hr = step_wrap(hr, 0, 23, inc);
                  o.write_kind = WRITE_TIME;
               end
               FIELD_MINUTE: begin
                  mi = step_wrap(mi, 0, 59, inc);
                  o.write_kind = WRITE_TIME;
               end
               FIELD_SECOND: begin
                  se = step_wrap(se, 0, 59, inc);
                  o.write_kind = WRITE_TIME;
               end
               FIELD_YEAR: begin
                  yr = step_wrap(yr, 0, 99, inc);
                  o.write_kind = WRITE_DATE;
               end
               FIELD_MONTH: begin
                  mo = step_wrap(mo, 1, 12, inc);
                  o.write_kind = WRITE_DATE;
               end
               FIELD_DAY: begin
                  dy = step_wrap(dy, 1, days_in(mo, yr), inc);
                  o.write_kind = WRITE_DATE;
               end
               FIELD_WEEKDAY: begin
                  wd = step_wrap(wd, 1, 7, inc);
                  o.write_kind = WRITE_DATE;
               end
               FIELD_ALARM_HOUR: begin
                  alarm_hr = 5'(step_wrap(alarm_hr, 0, 23, inc));
                  o.write_kind = WRITE_ALARM;
               end
               FIELD_ALARM_MINUTE: begin
                  alarm_min = 6'(step_wrap(alarm_min, 0, 59, inc));
                  o.write_kind = WRITE_ALARM;
               end
               FIELD_ALARM_SECOND: begin
                  alarm_sec = 6'(step_wrap(alarm_sec, 0, 59, inc));
                  o.write_kind = WRITE_ALARM;
               end
               FIELD_ALARM_WDAY: begin
                  alarm_wd = 3'(step_wrap(alarm_wd, 1, 7, inc));
                  o.write_kind = WRITE_ALARM;
               end
               default: ;
            endcase
            case (o.write_kind)
               WRITE_TIME: begin
                  o.slot_a = 7'(hr);
                  o.slot_b = 6'(mi);
                  o.slot_c = 6'(se);
                  o.slot_d = '0;
               end
               WRITE_DATE: begin
                  o.slot_a = 7'(yr);
                  o.slot_b = 6'(mo);
                  o.slot_c = 6'(dy);
                  o.slot_d = 6'(wd);
               end
               WRITE_ALARM: begin
                  o.slot_a = 7'(alarm_wd);
                  o.slot_b = 6'(alarm_hr);
                  o.slot_c = 6'(alarm_min);
                  o.slot_d = 6'(alarm_sec);
               end
               default: ;
            endcase
         end
      end else begin
         if (key == KEY_UP) begin
            led_one = !led_one;
         end else if (key == KEY_DOWN) begin
            led_two = !led_two;
         end else if (key == KEY_TOGGLE) begin
            beeper_on = !beeper_on;
         end
      end

      o.first_led   = led_one;
      o.second_led  = led_two;
      o.beeper      = beeper_on;
      o.edit_on     = edit_mode;
      o.field_index = field_sel;
      return o;
   endfunction

   task automatic field_check(input string name, input int want, input int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic check_panel(input cskc_rsp_type want, input cskc_rsp_type got);
      field_check("first_led", want.first_led, got.first_led);
      field_check("second_led", want.second_led, got.second_led);
      field_check("beeper", want.beeper, got.beeper);
      field_check("edit_on", want.edit_on, got.edit_on);
      field_check("field_index", want.field_index, got.field_index);
      field_check("press_event", want.press_event, got.press_event);
      field_check("write_kind", want.write_kind, got.write_kind);
      field_check("slot_a", want.slot_a, got.slot_a);
      field_check("slot_b", want.slot_b, got.slot_b);
      field_check("slot_c", want.slot_c, got.slot_c);
      field_check("slot_d", want.slot_d, got.slot_d);
   endtask

   // Every result beat is compared with the oldest owed panel state.
   always @(posedge clock) begin : panel_monitor
      cskc_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (panel_due.size() == 0) begin
            fail_count++;
            $display("%0t: result beat with nothing owed, expected none, actual %h",
                     $time, rsp_data);
         end else begin
            want = panel_due.pop_front();
            check_panel(want, rsp_data);
            if (want.write_kind != WRITE_NONE) writes_seen++;
            if (want.press_event == PRESS_LONG) long_seen++;
            if (want.press_event == PRESS_SHORT) short_seen++;
         end
      end
   end

   // Send one tick; gaps come at random unless the flow is held steady.
   task automatic send_tick(input cskc_req_type item);
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (!req_ready);
      panel_due.push_back(advance_controller(item));
      items_sent++;
   endtask

   // Hold off the sender until every owed beat has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (panel_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      wait_drained();
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = value;
      if (idx == CSR_LONG_PRESS) begin
         long_cfg = value;
      end else begin
         qualify_cfg = value[7:0];
      end
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   function automatic int edge_pick(input int lo, input int hi);
      case ($urandom_range(3))
         0:       return lo;
         1:       return hi;
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   // Clock snapshot: pinned, full-width noise, or legal values leaning on edges.
   function automatic cskc_req_type snapshot();
      cskc_req_type r;
      r = '0;
      if (rtc_pinned) begin
         r = pinned_rtc;
      end else if ($urandom_range(9) == 0) begin
         r.rtc_hour    = 5'($urandom);
         r.rtc_minute  = 6'($urandom);
         r.rtc_second  = 6'($urandom);
         r.rtc_year    = 7'($urandom);
         r.rtc_month   = 4'($urandom);
         r.rtc_day     = 5'($urandom);
         r.rtc_weekday = 3'($urandom);
      end else begin
         r.rtc_hour    = 5'(edge_pick(0, 23));
         r.rtc_minute  = 6'(edge_pick(0, 59));
         r.rtc_second  = 6'(edge_pick(0, 59));
         r.rtc_year    = 7'(edge_pick(0, 99));
         r.rtc_month   = 4'(edge_pick(1, 12));
         r.rtc_day     = 5'($urandom_range(1) ? edge_pick(28, 31) : edge_pick(1, 31));
         r.rtc_weekday = 3'(edge_pick(1, 7));
      end
      return r;
   endfunction

   // Arguments say which keys are pressed; pin polarities are applied here.
   function automatic cskc_req_type key_tick(input bit u, input bit d, input bit t,
                                             input bit m);
      cskc_req_type r;
      r = snapshot();
      r.up_key_level     = u;
      r.down_key_level   = !d;
      r.toggle_key_level = !t;
      r.mode_key_level   = !m;
      return r;
   endfunction

   task automatic hold_keys(input bit u, input bit d, input bit t, input bit m, input int n);
      repeat (n) send_tick(key_tick(u, d, t, m));
   endtask

   task automatic tap_keys(input bit u, input bit d, input bit t, input int held,
                           input int rel);
      hold_keys(u, d, t, 1'b0, held);
      hold_keys(1'b0, 1'b0, 1'b0, 1'b0, rel);
   endtask

   task automatic press_mode(input int held, input int rel);
      hold_keys(1'b0, 1'b0, 1'b0, 1'b1, held);
      hold_keys(1'b0, 1'b0, 1'b0, 1'b0, rel);
   endtask

   task automatic step_key(input bit up);
      tap_keys(up, !up, 1'b0, 3, 1);
   endtask

   task automatic pin_clock(input int hr, input int mi, input int se, input int yr,
                            input int mo, input int dy, input int wd);
      pinned_rtc.rtc_hour    = 5'(hr);
      pinned_rtc.rtc_minute  = 6'(mi);
      pinned_rtc.rtc_second  = 6'(se);
      pinned_rtc.rtc_year    = 7'(yr);
      pinned_rtc.rtc_month   = 4'(mo);
      pinned_rtc.rtc_day     = 5'(dy);
      pinned_rtc.rtc_weekday = 3'(wd);
      rtc_pinned = 1'b1;
   endtask

   // Register defaults: a key tap, a qualified short press, an aborted press.
   task automatic test_reset_values();
      hold_keys(1'b0, 1'b0, 1'b0, 1'b0, 3);
      tap_keys(1'b1, 1'b0, 1'b0, 3, 1);
      press_mode(14, 1);
      press_mode(5, 1);
   endtask

   // Outside edit mode: each key, priority among keys, too-short and locked taps.
   task automatic test_key_priority();
      write_csr(CSR_LONG_PRESS, 16'd0);
      write_csr(CSR_QUALIFY_TICKS, 16'd0);
      tap_keys(1'b0, 1'b1, 1'b0, 3, 1);
      tap_keys(1'b0, 1'b0, 1'b1, 3, 1);
      tap_keys(1'b1, 1'b1, 1'b0, 3, 1);
      tap_keys(1'b0, 1'b1, 1'b1, 3, 1);
      tap_keys(1'b1, 1'b1, 1'b1, 3, 1);
      tap_keys(1'b0, 1'b1, 1'b0, 2, 1);
      tap_keys(1'b1, 1'b0, 1'b0, 6, 0);
      tap_keys(1'b0, 1'b1, 1'b0, 4, 1);
   endtask

   // Edit mode: walk all eleven fields, hitting wraps and month lengths.
   task automatic test_edit_steps();
      press_mode(3, 1);
      pin_clock(0, 59, 59, 99, 1, 31, 7);
      step_key(1'b0);
      pin_clock(31, 59, 59, 99, 1, 31, 7);
      step_key(1'b1);
      tap_keys(1'b0, 1'b0, 1'b1, 3, 1);
      press_mode(2, 1);
      step_key(1'b1);
      press_mode(2, 1);
      step_key(1'b0);
      press_mode(2, 1);
      step_key(1'b1);
      press_mode(2, 1);
      step_key(1'b0);
      pin_clock(0, 0, 0, 96, 0, 29, 0);
      step_key(1'b0);
      press_mode(2, 1);
      pin_clock(0, 0, 0, 96, 2, 29, 0);
      step_key(1'b1);
      pin_clock(0, 0, 0, 97, 2, 28, 0);
      step_key(1'b1);
      pin_clock(0, 0, 0, 97, 2, 1, 0);
      step_key(1'b0);
      press_mode(2, 1);
      step_key(1'b0);
      pin_clock(0, 0, 0, 97, 2, 1, 7);
      step_key(1'b1);
      press_mode(2, 1);
      step_key(1'b0);
      step_key(1'b1);
      press_mode(2, 1);
      step_key(1'b0);
      press_mode(2, 1);
      step_key(1'b0);
      press_mode(2, 1);
      step_key(1'b0);
      press_mode(2, 1);
      press_mode(3, 1);
      rtc_pinned = 1'b0;
   endtask

   // A hold equal to the threshold is short; one tick more makes it long.
   task automatic test_long_threshold();
      write_csr(CSR_LONG_PRESS, 16'd100);
      press_mode(102, 1);
      press_mode(103, 1);
   endtask

   // Mostly well-formed key taps and mode presses, with some noise mixed in.
   task automatic random_phase(input int n);
      int stop_at, pick, acc, held;
      bit u, d, t;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         acc  = ((qualify_cfg > 8'd1) ? int'(qualify_cfg) : 1) + 1;
         if (pick < 45) begin
            held = $urandom_range(2);
            u = (held == 0);
            d = (held == 1);
            t = (held == 2);
            if ($urandom_range(3) == 0) begin
               {u, d, t} = 3'($urandom);
            end
            tap_keys(u, d, t, $urandom_range(1, 7), $urandom_range(0, 3));
         end else if (pick < 62 || (pick < 72 && long_cfg > 16'd300)) begin
            held = acc + $urandom_range(0, (long_cfg < 16'd20) ? int'(long_cfg) : 20);
            press_mode(held, $urandom_range(1, 3));
         end else if (pick < 72) begin
            press_mode(acc + int'(long_cfg) + 1 + $urandom_range(0, 2), $urandom_range(1, 3));
         end else if (pick < 80) begin
            press_mode($urandom_range(1, acc), $urandom_range(1, 2));
         end else begin
            repeat ($urandom_range(1, 6)) begin
               send_tick(key_tick(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
            end
         end
      end
   endtask

   task automatic test_random_traffic();
      steady_flow = 1'b1;
      write_csr(CSR_LONG_PRESS, 16'd12);
      write_csr(CSR_QUALIFY_TICKS, 16'd2);
      random_phase(400);
      steady_flow = 1'b0;
      write_csr(CSR_LONG_PRESS, 16'd0);
      write_csr(CSR_QUALIFY_TICKS, 16'd0);
      random_phase(350);
      write_csr(CSR_LONG_PRESS, 16'd40);
      write_csr(CSR_QUALIFY_TICKS, 16'd1);
      random_phase(350);
      write_csr(CSR_LONG_PRESS, 16'hFFFF);
      write_csr(CSR_QUALIFY_TICKS, 16'h00FF);
      random_phase(350);
   endtask

   initial begin
      req_data = key_tick(1'b0, 1'b0, 1'b0, 1'b0);
      clear_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_key_priority();
      test_edit_steps();
      test_long_threshold();
      test_random_traffic();

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("Ran %0d ticks: key taps and priority, edit steps on all fields, %0d writes,",
               items_sent, writes_seen);
      $display("%0d short and %0d long mode presses over six register settings; %0d errors.",
               short_seen, long_seen, fail_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
